### src/ppsnr_pkg.sv
// ----------------------------------------------------------------------------
// ppsnr_pkg: shared types and constants
// Widths, limits and the plane record passed from front to back.
// ----------------------------------------------------------------------------
package ppsnr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 22;
  localparam int SUM_W       = 54;
  localparam int CNT_W       = COUNT_BITS + 1;
  localparam int DEPTH_W     = 5;
  localparam int EXP_W       = 6;
  localparam int FRAC_W      = 16;
  localparam int LOG_W       = EXP_W + FRAC_W;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET     = 5'd10;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX       = 5'd16;
  localparam logic [17:0]        DB_PER_LOG2_Q16 = 18'd197283;
  localparam logic signed [15:0] PSNR_MAX_Q8     = 16'sd30720;
  localparam logic signed [15:0] PSNR_MIN_Q8     = -16'sd24576;

  // one finished plane
  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [SAMPLE_BITS-1:0] max_err;
    logic [CNT_W-1:0]       count;
    logic                   ovf;
  } rec_t;

endpackage

### src/ppsnr_if.sv
// ----------------------------------------------------------------------------
// ppsnr channels
// Sample input, result output and bit depth write channels.
// ----------------------------------------------------------------------------
interface ppsnr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_ref;
  logic [15:0] sample_test;
  logic        last_sample;
  modport source (output valid, sample_ref, sample_test, last_sample, input ready);
  modport sink   (input valid, sample_ref, sample_test, last_sample, output ready);
endinterface

interface ppsnr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] psnr_q8;
  logic [53:0]        error_sum;
  logic [15:0]        max_abs_error;
  logic [22:0]        sample_count;
  logic               overflow;
  modport source (output valid, psnr_q8, error_sum, max_abs_error, sample_count, overflow,
                  input ready);
  modport sink   (input valid, psnr_q8, error_sum, max_abs_error, sample_count, overflow,
                  output ready);
endinterface

interface ppsnr_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] bit_depth;
  modport source (output valid, bit_depth, input ready);
  modport sink   (input valid, bit_depth, output ready);
endinterface

### src/plane_psnr_and_max_error_unit.sv
// ----------------------------------------------------------------------------
// plane_psnr_and_max_error_unit: plane PSNR and max error
// Samples enter at one pair per clock while the record queue has room; each
// plane's PSNR is worked out in the background after its last pair.
// ----------------------------------------------------------------------------
// Sample pairs are taken one per clock while the queue has room. A plane's
// statistics go into a two-entry record queue; the back end then works on
// each plane and waits for its result beat to be taken, using the shared log
// unit (a bit-wise normalize plus 16 squaring steps, run once for peak^2*count
// and once for the sum). Input stalls only while two finished planes wait for
// the back end.
module plane_psnr_and_max_error_unit
  import ppsnr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ppsnr_in_if.sink    samples,
  ppsnr_out_if.source results,
  ppsnr_cfg_if.sink   cfg
);

  logic [DEPTH_W-1:0] bit_depth;
  logic               push;
  rec_t               push_rec;
  logic               pop;
  logic               q_valid;
  logic               q_full;
  rec_t               q_rec;

  // bit depth register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth <= DEPTH_RESET;
    end else if (cfg.valid) begin
      bit_depth <= cfg.bit_depth;
    end
  end

  ppsnr_front u_front (
    .clk(clk), .rst(rst), .samples(samples),
    .q_full(q_full), .push(push), .push_rec(push_rec)
  );

  ppsnr_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_rec(push_rec),
    .pop(pop), .q_valid(q_valid), .q_full(q_full), .q_rec(q_rec)
  );

  ppsnr_back u_back (
    .clk(clk), .rst(rst), .bit_depth(bit_depth), .q_valid(q_valid),
    .q_rec(q_rec), .pop(pop), .results(results)
  );

  // queue never written while full
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("record pushed into full queue");

  // a zero error sum reports the top PSNR
  a_zero_sum_top: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.error_sum == '0) |-> results.psnr_q8 == PSNR_MAX_Q8)
    else $error("zero sum without top PSNR");

  // every reported plane has at least one pair
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.sample_count != '0)
    else $error("result with zero count");

  // a pop leaves the back end busy
  a_pop_busy: assert property (@(posedge clk) disable iff (rst) pop |=> !pop)
    else $error("back end popped twice in a row");

endmodule

### src/ppsnr_front.sv
// ----------------------------------------------------------------------------
// ppsnr_front: per-sample accumulation
// Sums squared differences, tracks max error and counts pairs; on the last
// pair pushes the plane record and clears.
// ----------------------------------------------------------------------------
module ppsnr_front
  import ppsnr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ppsnr_in_if.sink      samples,
  input  logic          q_full,
  output logic          push,
  output rec_t          push_rec
);

  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] max_err;
  logic [CNT_W-1:0]       count;
  logic                   ovf;

  logic [SUM_W-1:0]       sum_next;
  logic [SAMPLE_BITS-1:0] max_next;
  logic [CNT_W-1:0]       count_next;
  logic                   ovf_next;

  logic [SAMPLE_BITS-1:0]   diff;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic [SUM_W:0]           sum_add;
  logic                     accept;

  assign samples.ready = !q_full;
  assign accept = samples.valid && samples.ready;

  // difference, square and saturating add
  always_comb begin
    diff = (samples.sample_ref >= samples.sample_test) ?
           (samples.sample_ref - samples.sample_test) :
           (samples.sample_test - samples.sample_ref);
    sq = {{SAMPLE_BITS{1'b0}}, diff} * {{SAMPLE_BITS{1'b0}}, diff};
    sum_add = {1'b0, sum} + {{(SUM_W+1-2*SAMPLE_BITS){1'b0}}, sq};
    max_next = (diff > max_err) ? diff : max_err;
    sum_next = sum;
    count_next = count;
    ovf_next = ovf;
    if (count >= (CNT_W'(1) << COUNT_BITS)) begin
      ovf_next = 1'b1;
    end else begin
      count_next = count + CNT_W'(1);
      if (sum_add[SUM_W]) begin
        sum_next = {SUM_W{1'b1}};
        ovf_next = 1'b1;
      end else begin
        sum_next = sum_add[SUM_W-1:0];
      end
    end
  end

  assign push = accept && samples.last_sample;
  assign push_rec = '{sum: sum_next, max_err: max_next, count: count_next, ovf: ovf_next};

  // running state, cleared after each plane
  always_ff @(posedge clk) begin
    if (rst || push) begin
      sum <= '0;
      max_err <= '0;
      count <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      sum <= sum_next;
      max_err <= max_next;
      count <= count_next;
      ovf <= ovf_next;
    end
  end

endmodule

### src/ppsnr_queue.sv
// ----------------------------------------------------------------------------
// ppsnr_queue: two-entry plane record queue
// Decouples the sample front from the log back.
// ----------------------------------------------------------------------------
module ppsnr_queue
  import ppsnr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output rec_t q_rec
);

  rec_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign q_valid = (fill != 2'd0);
  assign q_full  = (fill == 2'd2);
  assign q_rec   = slot[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### src/ppsnr_back.sv
// ----------------------------------------------------------------------------
// ppsnr_back: per-plane PSNR sequencer
// Forms peak^2*count, takes both base-2 logs on one shared unit (bit-wise
// normalize, then squaring steps), scales to dB and holds the result.
// ----------------------------------------------------------------------------
module ppsnr_back
  import ppsnr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [DEPTH_W-1:0] bit_depth,
  input  logic               q_valid,
  input  rec_t               q_rec,
  output logic               pop,
  ppsnr_out_if.source        results
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PSQ   = 4'd1;
  localparam logic [3:0] S_NUM   = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_FRAC  = 4'd4;
  localparam logic [3:0] S_LDONE = 4'd5;
  localparam logic [3:0] S_DIFF  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_WAIT  = 4'd8;

  logic [3:0]             state;
  rec_t                   job;
  logic [31:0]            psq;
  logic [SUM_W-1:0]       lx;
  logic [EXP_W-1:0]       le;
  logic [31:0]            m;
  logic [FRAC_W-1:0]      frac;
  logic [3:0]             iter;
  logic                   sel_sum;
  logic [LOG_W-1:0]       lnum;
  logic [LOG_W-1:0]       lsum;
  logic signed [40:0]     prod;

  logic [DEPTH_W-1:0]     depth_c;
  logic [16:0]            peak_w;
  logic [15:0]            peak;
  logic [63:0]            msq;
  logic [32:0]            t;
  logic signed [22:0]     d;
  logic signed [40:0]     rnd;
  logic signed [16:0]     r;
  logic signed [15:0]     psnr;
  logic [54:0]            num_w;

  // clamped depth and peak
  always_comb begin
    if (bit_depth == '0) begin
      depth_c = DEPTH_W'(1);
    end else if (bit_depth > DEPTH_MAX) begin
      depth_c = DEPTH_MAX;
    end else begin
      depth_c = bit_depth;
    end
    peak_w = (17'd1 << depth_c) - 17'd1;
    peak = peak_w[15:0];
  end

  // datapath pieces
  always_comb begin
    msq = {32'd0, m} * {32'd0, m};
    t = msq[63:31];
    num_w = {23'd0, psq} * {32'd0, job.count};
    d = $signed({1'b0, lnum}) - $signed({1'b0, lsum});
    rnd = (prod + 41'sd8388608) >>> 24;
    r = rnd[16:0];
    if (r > 17'(PSNR_MAX_Q8)) begin
      psnr = PSNR_MAX_Q8;
    end else if (r < 17'(PSNR_MIN_Q8)) begin
      psnr = PSNR_MIN_Q8;
    end else begin
      psnr = r[15:0];
    end
  end

  assign pop = (state == S_IDLE) && q_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      results.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job <= q_rec;
            state <= S_PSQ;
          end
        end
        S_PSQ: begin
          psq <= {16'd0, peak} * {16'd0, peak};
          state <= S_NUM;
        end
        S_NUM: begin
          lx <= num_w[SUM_W-1:0];
          le <= EXP_W'(SUM_W - 1);
          sel_sum <= 1'b0;
          state <= S_NORM;
        end
        // one bit of normalization per cycle
        S_NORM: begin
          if (lx[SUM_W-1] || le == '0) begin
            m <= lx[SUM_W-1:SUM_W-32];
            frac <= '0;
            iter <= '0;
            state <= S_FRAC;
          end else begin
            lx <= lx << 1;
            le <= le - EXP_W'(1);
          end
        end
        // one fraction bit per squaring
        S_FRAC: begin
          frac <= {frac[FRAC_W-2:0], t[32]};
          m <= t[32] ? t[32:1] : t[31:0];
          iter <= iter + 4'd1;
          if (iter == 4'd15) begin
            state <= S_LDONE;
          end
        end
        S_LDONE: begin
          if (!sel_sum) begin
            lnum <= {le, frac};
            lx <= job.sum;
            le <= EXP_W'(SUM_W - 1);
            sel_sum <= 1'b1;
            state <= S_NORM;
          end else begin
            lsum <= {le, frac};
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          prod <= 41'(d) * $signed({23'd0, DB_PER_LOG2_Q16});
          state <= S_OUT;
        end
        S_OUT: begin
          results.psnr_q8 <= (job.sum == '0) ? PSNR_MAX_Q8 : psnr;
          results.error_sum <= job.sum;
          results.max_abs_error <= job.max_err;
          results.sample_count <= job.count;
          results.overflow <= job.ovf;
          results.valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/psnr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psnr_checker: plane statistics scoreboard
// Watches the sample, result and bit depth channels, keeps its own running
// plane statistics, works out the PSNR of every finished plane and compares
// each result beat field by field with the oldest plane waiting.
// ----------------------------------------------------------------------------
module psnr_checker
  import ppsnr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ppsnr_in_if   sample_ch,
  ppsnr_out_if  result_ch,
  ppsnr_cfg_if  cfg_ch,
  output int    fail_count,
  output int    planes_pending,
  output int    planes_checked,
  output int    pairs_seen
);

  localparam longint unsigned SUM_LIMIT  = (64'd1 << SUM_W) - 1;
  localparam longint unsigned COUNT_FULL = 64'd1 << COUNT_BITS;

  typedef struct packed {
    logic signed [15:0] psnr_q8;
    logic [SUM_W-1:0]   error_sum;
    logic [15:0]        max_abs_error;
    logic [CNT_W-1:0]   sample_count;
    logic               overflow;
  } plane_stats_t;

  plane_stats_t planes_due[$];

  // running statistics of the open plane
  logic [DEPTH_W-1:0] depth_now;
  longint unsigned    sq_sum;
  longint unsigned    worst_diff;
  longint unsigned    pair_total;
  logic               saturated;

  // log2 in Q16 by repeated squaring of the normalized value
  function automatic longint unsigned log2_fixed(input longint unsigned x);
    longint unsigned e;
    longint unsigned m;
    longint unsigned frac;
    e = 0;
    frac = 0;
    if (x == 0) return 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e >= 31) m = x >> (e - 31);
    else m = x << (31 - e);
    for (int i = 0; i < FRAC_W; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (e << 16) + frac;
  endfunction

  // PSNR in 1/256 dB from sum, count and depth
  function automatic logic signed [15:0] psnr_of_plane(input longint unsigned sum,
                                                       input longint unsigned count,
                                                       input logic [DEPTH_W-1:0] depth);
    longint unsigned peak;
    longint d;
    longint r;
    longint unsigned eff;
    if (sum == 0) return PSNR_MAX_Q8;
    eff = depth;
    if (eff < 1) eff = 1;
    if (eff > DEPTH_MAX) eff = DEPTH_MAX;
    peak = (64'd1 << eff) - 1;
    d = longint'(log2_fixed(peak * peak * count)) - longint'(log2_fixed(sum));
    r = (d * longint'(DB_PER_LOG2_Q16) + (64'sd1 <<< 23)) >>> 24;
    if (r > PSNR_MAX_Q8) r = PSNR_MAX_Q8;
    if (r < PSNR_MIN_Q8) r = PSNR_MIN_Q8;
    return r[15:0];
  endfunction

  always @(posedge clk) begin
    longint unsigned diff;
    plane_stats_t    due;
    plane_stats_t    got;
    if (rst) begin
      depth_now      <= DEPTH_RESET;
      sq_sum         = 0;
      worst_diff     = 0;
      pair_total     = 0;
      saturated      = 0;
      planes_due.delete();
      planes_pending <= 0;
      fail_count     <= 0;
      planes_checked <= 0;
      pairs_seen     <= 0;
    end else begin
      // bit depth write beat
      if (cfg_ch.valid && cfg_ch.ready) depth_now <= cfg_ch.bit_depth;

      // sample beat: accumulate, close the plane on last
      if (sample_ch.valid && sample_ch.ready) begin
        pairs_seen <= pairs_seen + 1;
        diff = (sample_ch.sample_ref >= sample_ch.sample_test) ?
               sample_ch.sample_ref - sample_ch.sample_test :
               sample_ch.sample_test - sample_ch.sample_ref;
        if (diff > worst_diff) worst_diff = diff;
        if (pair_total >= COUNT_FULL) begin
          saturated = 1;
        end else begin
          pair_total++;
          if (diff * diff > SUM_LIMIT - sq_sum) begin
            sq_sum = SUM_LIMIT;
            saturated = 1;
          end else begin
            sq_sum += diff * diff;
          end
        end
        if (sample_ch.last_sample) begin
          due.psnr_q8       = psnr_of_plane(sq_sum, pair_total, depth_now);
          due.error_sum     = sq_sum[SUM_W-1:0];
          due.max_abs_error = worst_diff[15:0];
          due.sample_count  = pair_total[CNT_W-1:0];
          due.overflow      = saturated;
          planes_due.push_back(due);
          sq_sum     = 0;
          worst_diff = 0;
          pair_total = 0;
          saturated  = 0;
        end
      end

      // result beat against the oldest finished plane
      if (result_ch.valid && result_ch.ready) begin
        got.psnr_q8       = result_ch.psnr_q8;
        got.error_sum     = result_ch.error_sum;
        got.max_abs_error = result_ch.max_abs_error;
        got.sample_count  = result_ch.sample_count;
        got.overflow      = result_ch.overflow;
        if (planes_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("%0t: result beat with no plane pending: psnr %0d sum %0d", $realtime,
                     got.psnr_q8, got.error_sum);
        end else begin
          due = planes_due.pop_front();
          planes_checked <= planes_checked + 1;
          if (got.psnr_q8 !== due.psnr_q8 || got.error_sum !== due.error_sum ||
              got.max_abs_error !== due.max_abs_error ||
              got.sample_count !== due.sample_count || got.overflow !== due.overflow) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("%0t: plane mismatch, expected psnr %0d sum %0d max %0d count %0d ovf %0b",
                       $realtime, due.psnr_q8, due.error_sum, due.max_abs_error,
                       due.sample_count, due.overflow);
              $display("      got                 psnr %0d sum %0d max %0d count %0d ovf %0b",
                       got.psnr_q8, got.error_sum, got.max_abs_error, got.sample_count,
                       got.overflow);
            end
          end
        end
      end

      // planes still waiting for their result beat
      planes_pending <= planes_due.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: plane PSNR unit testbench
// Drives directed and random planes under several bit depths and handshake
// idling patterns, including a long result stall, and reports the verdict
// from the scoreboard's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import ppsnr_pkg::*;

  localparam int LONG_HOLD  = 3000;
  localparam int DRAIN_WAIT = 400;

  logic clk;
  logic rst;
  int   fail_count;
  int   planes_pending;
  int   planes_checked;
  int   pairs_seen;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_left;
  logic hold_req;
  int   total_items;

  ppsnr_in_if  sample_ch ();
  ppsnr_out_if result_ch ();
  ppsnr_cfg_if cfg_ch ();

  plane_psnr_and_max_error_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  psnr_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .sample_ch      (sample_ch),
    .result_ch      (result_ch),
    .cfg_ch         (cfg_ch),
    .fail_count     (fail_count),
    .planes_pending (planes_pending),
    .planes_checked (planes_checked),
    .pairs_seen     (pairs_seen)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // long result hold-off countdown
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result receiver with random stalls
  always @(posedge clk) begin
    result_ch.ready <= !rst && hold_left == 0 && ($urandom_range(99) >= stall_pct);
  end

  // give up after a generous time
  initial begin
    #30000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.sample_ref  <= a;
    sample_ch.sample_test <= b;
    sample_ch.last_sample <= last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    total_items++;
  endtask

  // random plane, samples full range, close pairs inside the depth, or equal pairs with an occasional one-bit flip
  task automatic send_plane(input int len, input logic [DEPTH_W-1:0] depth);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] mask;
    int          kind;
    kind = $urandom_range(2);
    mask = (depth == 0) ? 16'h1 : (depth >= 16) ? 16'hFFFF : (16'h1 << depth) - 16'h1;
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      if (kind == 1) begin
        a = a & mask;
        b = 16'(a + $urandom_range(6) - 3) & mask;
      end else if (kind == 2) begin
        b = a;
        if ($urandom_range(9) == 0) b = a ^ (16'h1 << $urandom_range(15));
      end
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (planes_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] depth);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.bit_depth <= depth;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int plane_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return $urandom_range(1, 8);
    if (pick < 96) return $urandom_range(9, 64);
    return $urandom_range(65, 300);
  endfunction

  initial begin
    logic [DEPTH_W-1:0] depths[8];
    int                 phase_items;
    rst                   = 1'b1;
    hold_req              = 1'b0;
    sample_ch.valid       = 1'b0;
    sample_ch.sample_ref  = '0;
    sample_ch.sample_test = '0;
    sample_ch.last_sample = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.bit_depth      = DEPTH_RESET;
    send_idle_pct         = 0;
    stall_pct             = 0;
    total_items           = 0;
    depths = '{5'd10, 5'd1, 5'd16, 5'd0, 5'd31, 5'd8, 5'd12, 5'd20};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed planes at the reset depth
    send_pair(16'd0, 16'd0, 1'b1);            // zero error gives the 120 dB ceiling
    send_pair(16'd0, 16'hFFFF, 1'b1);         // worst single pair, largest possible error
    send_pair(16'hFFFF, 16'd0, 1'b0);
    send_pair(16'd123, 16'd123, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'h0001, 16'h0000, 1'b1);
    for (int i = 0; i < 4; i++) send_pair(16'd512, 16'd513, i == 3);
    send_pair(16'd1023, 16'd0, 1'b1);         // full scale error at depth 10
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    drain();

    // random phases over depths and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      write_depth(depths[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      phase_items = 0;
      if (ph == 5) begin
        // hold results off while planes keep coming, so the input backs up
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 12; i++) send_pair(16'($urandom), 16'($urandom), 1'b1);
        phase_items = 12;
      end
      if (ph == 3) write_depth(DEPTH_W'($urandom_range(1, 16)));
      while (phase_items < 180) begin
        int len;
        len = plane_len();
        send_plane(len, depths[ph]);
        phase_items += len;
      end
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;

    $display("Sent %0d sample pairs; %0d planes checked over several bit depth settings",
             pairs_seen, planes_checked);
    $display("Idling patterns: none, sender, receiver, both, plus one long result hold-off");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
src/ppsnr_pkg.sv
src/ppsnr_if.sv
src/ppsnr_front.sv
src/ppsnr_queue.sv
src/ppsnr_back.sv
src/plane_psnr_and_max_error_unit.sv
tb/psnr_checker.sv
tb/tb_top.sv
